[hdl/addressed_packet_receiver_replier_unit_assert.svh]
// Assertion macros for the top-level RTL file of the packet receiver/replier.
`ifndef ADDRESSED_PACKET_RECEIVER_REPLIER_UNIT_ASSERT_SVH
`define ADDRESSED_PACKET_RECEIVER_REPLIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define APRU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("apru assertion failed");

// Next-cycle implication, disabled while reset is held.
`define APRU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("apru assertion failed");

`endif

[hdl/apru_pkg.sv]
// ----------------------------------------------------------------------------
// apru_pkg
// Types and constants shared by the packet receiver/replier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package apru_pkg;

    localparam int FRAME_MAX = 4;                 // longest reply frame in bytes
    localparam int IDX_W     = $clog2(FRAME_MAX);

    localparam logic [3:0] LEN_SHORT   = 4'h2;    // header length nibble, 2-byte body
    localparam logic [3:0] LEN_CHAN    = 4'h3;    // header length nibble, 3-byte body
    localparam logic [7:0] ERR_BAD_SUM = 8'h10;
    localparam logic [7:0] PING_REPLY  = 8'hF0;
    localparam logic [3:0] CMD_PING    = 4'hF;
    localparam logic [3:0] CMD_CHAN    = 4'hA;

    localparam logic [IDX_W-1:0] LAST_IDX_SHORT = IDX_W'(2);
    localparam logic [IDX_W-1:0] LAST_IDX_CHAN  = IDX_W'(3);

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] data;     // data[0] goes out first
        logic [IDX_W-1:0]          last_idx; // index of the checksum byte
        logic [3:0]                chan;     // channel number, first byte only
        logic                      chan_wr;  // channel update, first byte only
    } frame_t;

endpackage

`default_nettype wire

[hdl/addressed_packet_receiver_replier_unit.sv]
// ----------------------------------------------------------------------------
// addressed_packet_receiver_replier_unit
// Addressed packet receiver with reply frame generation.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received serial word per handshake, with the level of the
//   input pins sampled alongside it. m_ channel: reply words; tlast marks the
//   checksum word that ends a frame. cfg_wr_en/cfg_wr_data set the device
//   address; write it only while the block is idle.
//   A word is held in an input register and parsed there; the reply frame of
//   a completing word is loaded into a frame register, from which its reply
//   words show on m_. Words that give no reply pass at one per cycle. A
//   completing word is held while a previous frame is still being sent, so
//   the sustained rate is set by the frame register draining one word per
//   cycle while m_tready is high, for frames of up to four words. When
//   m_tready is low the frame holds; words that give no reply still pass,
//   and s_tready drops once a completing word waits in the input register.
//   Reset clears the parser, clears the device address to zero and empties
//   the input and frame registers.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_packet_receiver_replier_unit import apru_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,   // device_address
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // [7:0] rx_byte, [15:8] port_pins
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,       // [7:0] tx_byte, [11:8] channel_select,
                                            // [12] channel_write, [15:13] zero
    output logic             m_tlast        // last_byte
);

    `include "addressed_packet_receiver_replier_unit_assert.svh"

    logic [3:0]       dev_addr_reg;
    logic             in_valid_reg;
    logic [15:0]      in_data_reg;
    logic             frm_valid_reg;
    frame_t           frm_reg;
    logic [IDX_W-1:0] idx_reg;

    logic             has_frame;
    frame_t           frame;
    logic             frm_done;
    logic             frm_free;
    logic             advance;
    logic             load;

    apru_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_data_reg[7:0]),
        .port_pins (in_data_reg[15:8]),
        .dev_addr  (dev_addr_reg),
        .has_frame (has_frame),
        .frame     (frame)
    );

    assign frm_done = frm_valid_reg && m_tready && (idx_reg == frm_reg.last_idx);
    assign frm_free = !frm_valid_reg || frm_done;
    // hold a completing word until the frame register can take its reply
    assign advance  = in_valid_reg && (!has_frame || frm_free);
    assign load     = advance && has_frame;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= 4'd0;
        end else if (cfg_wr_en) begin
            dev_addr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frm_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (load) begin
            frm_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (frm_done) begin
            frm_valid_reg <= 1'b0;
        end else if (frm_valid_reg && m_tready) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frm_reg <= frame;
        end
    end

    always_comb begin
        m_tvalid = frm_valid_reg;
        m_tlast  = frm_valid_reg && (idx_reg == frm_reg.last_idx);
        m_tdata  = '0;
        m_tdata[7:0] = frm_reg.data[idx_reg];
        if (idx_reg == '0) begin
            m_tdata[11:8] = frm_reg.chan;
            m_tdata[12]   = frm_reg.chan_wr;
        end
    end

    `APRU_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, load, frm_free)
    `APRU_ASSERT_NEXT(a_load_starts, aclk, aresetn, load, m_tvalid && (idx_reg == '0))
    `APRU_ASSERT_NEXT(a_held_word, aclk, aresetn, in_valid_reg && !advance,
                      in_valid_reg && $stable(in_data_reg))
    `APRU_ASSERT_IMPL(a_chan_first, aclk, aresetn, m_tvalid && m_tdata[12],
                      (idx_reg == '0) && !m_tlast)

endmodule

`default_nettype wire

[hdl/apru_parse.sv]
// ----------------------------------------------------------------------------
// apru_parse
// Packet parser: tracks header, length, command and running sum, and builds
// the reply frame, if any, on the byte that completes a packet for this device.
// ----------------------------------------------------------------------------
`default_nettype none

module apru_parse import apru_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,        // consume the presented word
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] port_pins,
    input  wire logic [3:0] dev_addr,
    output logic            has_frame,   // presented word completes a reply
    output frame_t          frame
);

    logic [3:0] bytes_left_reg, bytes_left_next;
    logic       skipping_reg, skipping_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] cmd_reg, cmd_next;
    logic       first_reg, first_next;

    logic [3:0] left_dec;
    logic [7:0] cmd_eff;
    logic [7:0] total;
    logic [7:0] hdr_short, hdr_chan, pins_n;

    always_comb begin
        left_dec  = bytes_left_reg - 4'd1;
        cmd_eff   = first_reg ? cmd_reg : rx_byte;
        total     = sum_reg + rx_byte;
        hdr_short = {dev_addr, LEN_SHORT};
        hdr_chan  = {dev_addr, LEN_CHAN};
        pins_n    = ~port_pins;

        bytes_left_next = bytes_left_reg;
        skipping_next   = skipping_reg;
        sum_next        = sum_reg;
        cmd_next        = cmd_reg;
        first_next      = first_reg;
        has_frame       = 1'b0;
        frame           = '0;

        if (bytes_left_reg == 4'd0) begin
            // header word
            bytes_left_next = rx_byte[3:0];
            skipping_next   = (rx_byte[7:4] != dev_addr);
            sum_next        = rx_byte;
            first_next      = 1'b0;
        end else begin
            bytes_left_next = left_dec;
            if (!skipping_reg) begin
                cmd_next   = cmd_eff;
                first_next = 1'b1;
                if (left_dec != 4'd0) begin
                    sum_next = total;
                end else begin
                    sum_next = 8'd0;
                    if (total != 8'd0) begin
                        has_frame     = 1'b1;
                        frame.data[0] = hdr_short;
                        frame.data[1] = ERR_BAD_SUM;
                        frame.data[2] = 8'd0 - (hdr_short + ERR_BAD_SUM);
                        frame.last_idx = LAST_IDX_SHORT;
                    end else if (cmd_eff[7:4] == CMD_PING) begin
                        has_frame     = 1'b1;
                        frame.data[0] = hdr_short;
                        frame.data[1] = PING_REPLY;
                        frame.data[2] = 8'd0 - (hdr_short + PING_REPLY);
                        frame.last_idx = LAST_IDX_SHORT;
                    end else if (cmd_eff[7:4] == CMD_CHAN) begin
                        has_frame     = 1'b1;
                        frame.data[0] = hdr_chan;
                        frame.data[1] = cmd_eff;
                        frame.data[2] = pins_n;
                        frame.data[3] = 8'd0 - (hdr_chan + cmd_eff + pins_n);
                        frame.last_idx = LAST_IDX_CHAN;
                        frame.chan     = cmd_eff[3:0];
                        frame.chan_wr  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 4'd0;
            skipping_reg   <= 1'b0;
            sum_reg        <= 8'd0;
            cmd_reg        <= 8'd0;
            first_reg      <= 1'b0;
        end else if (step) begin
            bytes_left_reg <= bytes_left_next;
            skipping_reg   <= skipping_next;
            sum_reg        <= sum_next;
            cmd_reg        <= cmd_next;
            first_reg      <= first_next;
        end
    end

endmodule

`default_nettype wire

[bench/tb_addressed_packet_receiver_replier_unit.sv]
// ----------------------------------------------------------------------------
// tb_addressed_packet_receiver_replier_unit
// Self-checking bench for the addressed packet receiver/replier.
// A directed table covers empty headers, ping, bad checksum, one-byte
// payloads, channel-select commands, ignored commands and foreign packets.
// Random phases follow under several device addresses, mostly well-formed
// packets with random content, mixed with foreign, empty and noise packets.
// Every reply word is compared field by field against the replies typed into
// the table or an in-bench predictor, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_addressed_packet_receiver_replier_unit;
    import apru_pkg::*;

    localparam int STALL_LIMIT  = 500;   // cycles with no word moving
    localparam int PHASE_WORDS  = 56;
    localparam int SETTLE_TICKS = 8;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
        logic [3:0] chan;
        logic       wr;
    } reply_t;

    typedef struct packed {
        logic [7:0]       rx;
        logic [7:0]       pins;
        logic             typed;   // use the replies typed into the row
        logic [2:0]       n;
        reply_t [3:0]     r;
    } row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [3:0]  cfg_wr_data = 4'h0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'h0000;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // predictor copy of the parser state and the address register
    logic [3:0]  dev_addr    = 4'h0;
    logic [3:0]  pk_left     = 4'h0;
    logic        pk_skip     = 1'b0;
    logic [7:0]  pk_sum      = 8'h00;
    logic [7:0]  pk_cmd      = 8'h00;
    logic        pk_cmd_seen = 1'b0;

    reply_t      pending_replies [$];
    int          errors       = 0;
    int          words_sent   = 0;
    int          stall_cycles = 0;
    bit          moving       = 1'b0;
    bit          fast_sender  = 1'b0;
    bit          fast_receiver = 1'b0;

    addressed_packet_receiver_replier_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic reply_t reply_byte(input logic [7:0] tx, input logic last,
                                          input logic [3:0] chan = 4'h0,
                                          input logic wr = 1'b0);
        reply_t r;
        r.tx   = tx;
        r.last = last;
        r.chan = chan;
        r.wr   = wr;
        return r;
    endfunction

    function automatic row_t row(input logic [7:0] rx, input logic [7:0] pins,
                                 input logic typed = 1'b0, input int n = 0,
                                 input logic [7:0] b0 = 8'h00,
                                 input logic [7:0] b1 = 8'h00,
                                 input logic [7:0] b2 = 8'h00);
        row_t w;
        w.rx    = rx;
        w.pins  = pins;
        w.typed = typed;
        w.n     = 3'(n);
        w.r[0]  = reply_byte(b0, n == 1);
        w.r[1]  = reply_byte(b1, n == 2);
        w.r[2]  = reply_byte(b2, n == 3);
        w.r[3]  = '0;
        return w;
    endfunction

    // Advance the parser by one received word and build the reply frame it completes.
    task automatic predict_reply(input logic [7:0] rx, input logic [7:0] pins,
                                 output int n, output reply_t [3:0] fr);
        logic [7:0] b0, b1, b2, cs;
        n  = 0;
        fr = '0;
        if (pk_left == 4'h0) begin
            pk_left     = rx[3:0];
            pk_skip     = (rx[7:4] != dev_addr);
            pk_sum      = rx;
            pk_cmd_seen = 1'b0;
            return;
        end
        pk_left = pk_left - 4'h1;
        if (pk_skip)
            return;
        if (!pk_cmd_seen) begin
            pk_cmd      = rx;
            pk_cmd_seen = 1'b1;
        end
        if (pk_left != 4'h0) begin
            pk_sum = pk_sum + rx;
            return;
        end
        if (8'(pk_sum + rx) != 8'h00) begin
            b0    = {dev_addr, LEN_SHORT};
            b1    = ERR_BAD_SUM;
            cs    = 8'h00 - b0 - b1;
            fr[0] = reply_byte(b0, 1'b0);
            fr[1] = reply_byte(b1, 1'b0);
            fr[2] = reply_byte(cs, 1'b1);
            n     = 3;
        end else if (pk_cmd[7:4] == CMD_PING) begin
            b0    = {dev_addr, LEN_SHORT};
            b1    = PING_REPLY;
            cs    = 8'h00 - b0 - b1;
            fr[0] = reply_byte(b0, 1'b0);
            fr[1] = reply_byte(b1, 1'b0);
            fr[2] = reply_byte(cs, 1'b1);
            n     = 3;
        end else if (pk_cmd[7:4] == CMD_CHAN) begin
            b0    = {dev_addr, LEN_CHAN};
            b1    = pk_cmd;
            b2    = ~pins;
            cs    = 8'h00 - b0 - b1 - b2;
            fr[0] = reply_byte(b0, 1'b0, pk_cmd[3:0], 1'b1);
            fr[1] = reply_byte(b1, 1'b0);
            fr[2] = reply_byte(b2, 1'b0);
            fr[3] = reply_byte(cs, 1'b1);
            n     = 4;
        end
        pk_sum = 8'h00;
    endtask

    task automatic send_word(input row_t w);
        int gap, n;
        reply_t [3:0] fr;
        gap = fast_sender ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_reply(w.rx, w.pins, n, fr);
        if (w.typed) begin
            n  = w.n;
            fr = w.r;
        end
        for (int i = 0; i < n; i++)
            pending_replies.push_back(fr[i]);
        s_tvalid <= 1'b1;
        s_tdata  <= {w.pins, w.rx};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        words_sent++;
    endtask

    // Hold the sender until every reply has come, then let the pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic send_packet();
        int roll, len, pick;
        logic [7:0] hdr, b, sum;
        logic [3:0] dst;
        roll = $urandom_range(0, 99);
        fast_sender = ($urandom_range(0, 3) == 0);
        if (roll < 8) begin
            send_word(row({4'($urandom()), 4'h0}, 8'($urandom())));
            return;
        end
        if (roll < 14) begin
            // noise: random header, then as many random words as it announces
            hdr = 8'($urandom());
            send_word(row(hdr, 8'($urandom())));
            for (int i = 0; i < hdr[3:0]; i++)
                send_word(row(8'($urandom()), 8'($urandom())));
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
        dst = (roll < 28) ? (dev_addr ^ 4'($urandom_range(1, 15))) : dev_addr;
        hdr = {dst, 4'(len)};
        sum = hdr;
        send_word(row(hdr, 8'($urandom())));
        for (int i = 0; i < len; i++) begin
            if (i == len - 1) begin
                b = 8'h00 - sum;
                if ($urandom_range(0, 6) == 0)
                    b = b + 8'($urandom_range(1, 255));
            end else if (i == 0) begin
                pick = $urandom_range(0, 4);
                if (pick < 2)
                    b = {CMD_PING, 4'($urandom())};
                else if (pick < 4)
                    b = {CMD_CHAN, 4'($urandom())};
                else
                    b = 8'($urandom());
            end else begin
                b = 8'($urandom());
            end
            sum = sum + b;
            send_word(row(b, 8'($urandom())));
        end
    endtask

    // stimulus and phases
    initial begin
        row_t plan [$];
        logic [3:0] addr_plan [4];
        int start, pkts;
        addr_plan = '{4'hF, 4'h0, 4'h5, 4'($urandom())};

        // device address is zero after reset
        plan.push_back(row(8'h00, 8'h00, 1'b1, 0));                       // empty header
        plan.push_back(row(8'h02, 8'h00));
        plan.push_back(row(8'hF0, 8'hFF));
        plan.push_back(row(8'h0E, 8'h00, 1'b1, 3, 8'h02, 8'hF0, 8'h0E));  // ping
        plan.push_back(row(8'h02, 8'hFF));
        plan.push_back(row(8'hF0, 8'h00));
        plan.push_back(row(8'h00, 8'hFF, 1'b1, 3, 8'h02, 8'h10, 8'hEE));  // bad checksum
        plan.push_back(row(8'h01, 8'h00));
        plan.push_back(row(8'hFF, 8'hFF, 1'b1, 3, 8'h02, 8'hF0, 8'h0E));  // one-byte ping
        plan.push_back(row(8'h01, 8'hFF));
        plan.push_back(row(8'h00, 8'h00, 1'b1, 3, 8'h02, 8'h10, 8'hEE));  // one-byte, bad
        plan.push_back(row(8'h02, 8'h00));
        plan.push_back(row(8'hA7, 8'hFF));
        plan.push_back(row(8'h57, 8'h00));                                // channel, pins low
        plan.push_back(row(8'h03, 8'h00));
        plan.push_back(row(8'hAF, 8'h00));
        plan.push_back(row(8'h55, 8'h00));
        plan.push_back(row(8'hF9, 8'hFF));                                // channel, pins high
        plan.push_back(row(8'h02, 8'h00));
        plan.push_back(row(8'h12, 8'h00));
        plan.push_back(row(8'hEC, 8'h00, 1'b1, 0));                       // ignored command
        plan.push_back(row(8'h53, 8'h5A));
        plan.push_back(row(8'hAA, 8'hA5));
        plan.push_back(row(8'hFF, 8'hFF));
        plan.push_back(row(8'h00, 8'h00, 1'b1, 0));                       // foreign packet

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            fast_sender = (k >= 18);
            send_word(plan[k]);
        end

        for (int p = 0; p < 4; p++) begin
            settle();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= addr_plan[p];
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            dev_addr = addr_plan[p];
            start = words_sent;
            pkts  = 0;
            while (words_sent - start < PHASE_WORDS) begin
                send_packet();
                pkts++;
                // hold off now and then until every reply is out
                if ((p == 0 && pkts == 6) || $urandom_range(0, 24) == 0)
                    settle();
            end
        end

        settle();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (pending_replies.size() != 0) begin
            $display("%0t: %0d reply words never arrived", $time, pending_replies.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS addressed_packet_receiver_replier_unit");
        else
            $display("FAIL addressed_packet_receiver_replier_unit");
        $finish;
    end

    // reply sink and checker
    initial begin
        int gap, cnt;
        logic [15:0] got;
        logic got_last;
        reply_t want;
        cnt = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (cnt % 16 == 0)
                fast_receiver = ($urandom_range(0, 3) == 0);
            cnt++;
            gap = fast_receiver ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
            while (!m_tvalid) @(negedge aclk);
            got      = m_tdata;
            got_last = m_tlast;
            @(posedge aclk);
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply word, expected none got %04h last %0b",
                         $time, got, got_last);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (got[7:0] !== want.tx) begin
                    $display("%0t: tx_byte expected %02h got %02h", $time, want.tx, got[7:0]);
                    errors++;
                end
                if (got_last !== want.last) begin
                    $display("%0t: last_byte expected %0b got %0b", $time, want.last, got_last);
                    errors++;
                end
                if (got[11:8] !== want.chan) begin
                    $display("%0t: channel_select expected %01h got %01h",
                             $time, want.chan, got[11:8]);
                    errors++;
                end
                if (got[12] !== want.wr) begin
                    $display("%0t: channel_write expected %0b got %0b", $time, want.wr, got[12]);
                    errors++;
                end
                if (got[15:13] !== 3'b000) begin
                    $display("%0t: tdata pad expected 0 got %0h", $time, got[15:13]);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles in which no word moves on either side
    always @(negedge aclk)
        moving = (s_tvalid && s_tready) || (m_tvalid && m_tready);

    always @(posedge aclk) begin
        if (!aresetn || moving)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL addressed_packet_receiver_replier_unit");
            $finish;
        end
    end

endmodule
